// ===== design/bccd_pkg.sv =====
// shared types and codes for the button click combo detector
// no dependencies

package bccd_pkg;

  localparam int unsigned NumButtons = 3;
  localparam int unsigned CntW       = 16;
  localparam int unsigned StampW     = 32;
  localparam int unsigned InDataW    = 8;
  localparam int unsigned OutDataW   = 8;

  localparam logic [CntW-1:0] DebounceReset = 16'd50;
  localparam logic [CntW-1:0] LongReset     = 16'd750;

  // configuration register indexes
  localparam logic CfgDebounce = 1'b0;
  localparam logic CfgLong     = 1'b1;

  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,
    KIND_ALL  = 3'd1,
    KIND_B1B2 = 3'd2,
    KIND_B1B3 = 3'd3,
    KIND_B2B3 = 3'd4,
    KIND_B1   = 3'd5,
    KIND_B2   = 3'd6,
    KIND_B3   = 3'd7
  } kind_t;

  typedef logic [NumButtons-1:0] btn_t;

  typedef struct packed {
    logic [CntW-1:0] debounce_ticks;
    logic [CntW-1:0] long_press_ticks;
  } cfg_t;

  typedef struct packed {
    btn_t  stable_buttons;
    logic  long_press;
    kind_t click_kind;
  } result_t;

endpackage

// ===== design/bccd_core.sv =====
// input register, debounce state and per-tick evaluation of the detector
// depends on bccd_pkg

module bccd_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  bccd_pkg::btn_t  in_raw,
  input  bccd_pkg::cfg_t  cfg,
  input  logic            hold,
  output logic            res_vld,
  output bccd_pkg::result_t res
);
  import bccd_pkg::*;

  logic                in_vld_r;
  btn_t                raw_r;
  logic                advance;

  logic [StampW-1:0]   tick_r, tick_nxt;
  btn_t                prev_r, prev_nxt;
  btn_t                cap_r, cap_nxt;
  btn_t                stable_r, stable_nxt;
  btn_t                lastv_r, lastv_nxt;
  btn_t                busy_r, busy_nxt;
  btn_t                fin_r, fin_nxt;
  logic [CntW-1:0]     cnt_r   [NumButtons];
  logic [CntW-1:0]     cnt_nxt [NumButtons];
  logic [StampW-1:0]   prs_r   [NumButtons];
  logic [StampW-1:0]   prs_nxt [NumButtons];
  logic [StampW-1:0]   rel_r   [NumButtons];
  logic [StampW-1:0]   rel_nxt [NumButtons];

  logic [CntW-1:0]     len;
  btn_t                restart;
  btn_t                held;
  logic                expired;
  logic                all_done;
  logic                snap;
  logic [StampW-1:0]   dur [NumButtons];

  assign advance   = in_vld_r & ~hold;
  assign in_tready = ~in_vld_r | advance;
  assign len       = (cfg.debounce_ticks == '0) ? CntW'(1) : cfg.debounce_ticks;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      raw_r <= in_raw;
    end
  end

  // one tick of the model
  always_comb begin
    cap_nxt    = cap_r;
    busy_nxt   = busy_r;
    fin_nxt    = fin_r;
    stable_nxt = stable_r;
    lastv_nxt  = lastv_r;
    prev_nxt   = raw_r;
    tick_nxt   = tick_r + StampW'(1);
    restart    = '0;
    expired    = 1'b0;
    for (int i = 0; i < NumButtons; i++) begin
      cnt_nxt[i] = cnt_r[i];
      prs_nxt[i] = prs_r[i];
      rel_nxt[i] = rel_r[i];
      if (raw_r[i] != prev_r[i]) begin
        cap_nxt[i] = raw_r[i];
        if (raw_r[i] != lastv_r[i]) begin
          restart[i]  = 1'b1;
          busy_nxt[i] = 1'b1;
          fin_nxt[i]  = 1'b0;
          cnt_nxt[i]  = len;
        end
      end
      if (!restart[i] && cnt_r[i] != '0) begin
        cnt_nxt[i] = cnt_r[i] - CntW'(1);
        if (cnt_r[i] == CntW'(1)) begin
          fin_nxt[i] = 1'b1;
          expired    = 1'b1;
        end
      end
    end
    all_done = &(~busy_nxt | fin_nxt);
    snap     = expired & all_done;
    if (snap) begin
      for (int i = 0; i < NumButtons; i++) begin
        if (raw_r[i] == cap_nxt[i]) begin
          stable_nxt[i] = cap_nxt[i];
          if (cap_nxt[i]) begin
            rel_nxt[i] = tick_r;
          end else begin
            prs_nxt[i] = tick_r;
          end
        end
      end
      busy_nxt  = '0;
      fin_nxt   = '0;
      lastv_nxt = stable_nxt;
    end
  end

  // held time per button with this tick's stamps
  always_comb begin
    for (int i = 0; i < NumButtons; i++) begin
      dur[i]  = rel_nxt[i] - prs_nxt[i];
      held[i] = dur[i] >= StampW'(cfg.long_press_ticks);
    end
  end

  // stable_nxt = new stable levels, lastv_r = previous valid levels
  always_comb begin
    res.stable_buttons = stable_nxt;
    res.long_press     = 1'b0;
    res.click_kind     = KIND_NONE;
    if (&stable_nxt && ~|lastv_r) begin
      res.click_kind = KIND_ALL;
    end else if (stable_nxt[0] && stable_nxt[1] && !lastv_r[0] && !lastv_r[1]
                 && stable_nxt[2] == lastv_r[2]) begin
      res.click_kind = KIND_B1B2;
      res.long_press = held[0] & held[1];
    end else if (stable_nxt[0] && stable_nxt[2] && !lastv_r[0] && !lastv_r[2]
                 && stable_nxt[1] == lastv_r[1]) begin
      res.click_kind = KIND_B1B3;
    end else if (stable_nxt[1] && stable_nxt[2] && !lastv_r[1] && !lastv_r[2]
                 && stable_nxt[0] == lastv_r[0]) begin
      res.click_kind = KIND_B2B3;
      res.long_press = held[1] & held[2];
    end else if (stable_nxt[0] && !lastv_r[0] && stable_nxt[1] == lastv_r[1]
                 && stable_nxt[2] == lastv_r[2]) begin
      res.click_kind = KIND_B1;
      res.long_press = held[0];
    end else if (stable_nxt[1] && !lastv_r[1] && stable_nxt[0] == lastv_r[0]
                 && stable_nxt[2] == lastv_r[2]) begin
      res.click_kind = KIND_B2;
    end else if (stable_nxt[2] && !lastv_r[2] && stable_nxt[0] == lastv_r[0]
                 && stable_nxt[1] == lastv_r[1]) begin
      res.click_kind = KIND_B3;
      res.long_press = held[2];
    end
  end

  assign res_vld = advance & snap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r   <= '0;
      prev_r   <= '1;
      cap_r    <= '1;
      stable_r <= '1;
      lastv_r  <= '1;
      busy_r   <= '0;
      fin_r    <= '0;
      for (int i = 0; i < NumButtons; i++) begin
        cnt_r[i] <= '0;
        prs_r[i] <= '0;
        rel_r[i] <= '0;
      end
    end else if (advance) begin
      tick_r   <= tick_nxt;
      prev_r   <= prev_nxt;
      cap_r    <= cap_nxt;
      stable_r <= stable_nxt;
      lastv_r  <= lastv_nxt;
      busy_r   <= busy_nxt;
      fin_r    <= fin_nxt;
      for (int i = 0; i < NumButtons; i++) begin
        cnt_r[i] <= cnt_nxt[i];
        prs_r[i] <= prs_nxt[i];
        rel_r[i] <= rel_nxt[i];
      end
    end
  end

  // a finished countdown belongs to a busy button
  a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_r & ~busy_r) == '0)
    else $error("finished flag without busy flag");

  // a running countdown is busy and not finished
  a_cnt_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ((cnt_r[0] == '0) || (busy_r[0] && !fin_r[0])) &&
    ((cnt_r[1] == '0) || (busy_r[1] && !fin_r[1])) &&
    ((cnt_r[2] == '0) || (busy_r[2] && !fin_r[2])))
    else $error("running countdown on idle button");

  // the tick counter moves once per evaluated beat
  a_tick: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (tick_r == $past(tick_r) + StampW'(1)))
    else $error("tick counter out of step");

endmodule

// ===== design/bccd_outbuf.sv =====
// result register with a one-entry skid stage for the output stream
// depends on bccd_pkg

module bccd_outbuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bccd_pkg::result_t push_res,
  output logic              full,
  output logic              out_tvalid,
  input  logic              out_tready,
  output bccd_pkg::result_t out_res
);
  import bccd_pkg::*;

  logic    out_vld_r;
  result_t out_res_r;
  logic    skid_vld_r;
  result_t skid_res_r;
  logic    free;

  assign free       = ~out_vld_r | out_tready;
  assign full       = skid_vld_r;
  assign out_tvalid = out_vld_r;
  assign out_res    = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (free) begin
      out_vld_r  <= skid_vld_r | push;
      skid_vld_r <= 1'b0;
    end else if (push) begin
      skid_vld_r <= 1'b1;
    end
    if (free) begin
      out_res_r <= skid_vld_r ? skid_res_r : push_res;
    end else if (push) begin
      skid_res_r <= push_res;
    end
  end

  // skid only fills behind a waiting result
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry without result in front");

  // no new result arrives while the skid is occupied
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> !push)
    else $error("result pushed into full buffer");

endmodule

// ===== design/button_click_combo_detector.sv =====
// top level of the three-button click and combo detector
// depends on bccd_pkg, bccd_core and bccd_outbuf
//
// usage:
//   in_*   : one beat per tick, in_tdata[2:0] are the raw active-low button
//            levels (1 released, 0 pressed)
//   out_*  : one beat per debounce snapshot, none on other ticks
//   cfg_*  : register writes, index 0 debounce length, index 1 long length,
//            written while the block is idle
// path: an accepted beat waits in the input register, and its result is
//   registered in the result register before it shows on out_tvalid
// throughput: one input beat per cycle while the skid stage is free; every tick
//   is evaluated in one pass of the per-button counters and the click classifier
// stalls: a result waiting on out_tready is kept in the result register, a
//   second one in the skid stage; only when the skid is occupied does
//   in_tready drop
// reset: stable levels read released, all countdowns idle, tick count zero,
//   debounce length 50 and long length 750 ticks

module button_click_combo_detector (
  input  logic                         clk,
  input  logic                         rst_n,
  // in_tdata: [2:0] raw_buttons, [7:3] zero
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [bccd_pkg::InDataW-1:0]  in_tdata,
  // out_tdata: [2:0] click_kind, [3] long_press, [6:4] stable_buttons, [7] zero
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [bccd_pkg::OutDataW-1:0] out_tdata,
  input  logic                         cfg_we,
  input  logic                         cfg_addr,
  input  logic [bccd_pkg::CntW-1:0]    cfg_wdata
);
  import bccd_pkg::*;

  cfg_t    cfg_r;
  logic    res_vld;
  result_t res;
  result_t out_res;
  logic    ob_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks   <= DebounceReset;
      cfg_r.long_press_ticks <= LongReset;
    end else if (cfg_we) begin
      case (cfg_addr)
        CfgDebounce: cfg_r.debounce_ticks   <= cfg_wdata;
        CfgLong:     cfg_r.long_press_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // debounce state and classification, one tick per beat
  bccd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_raw    (in_tdata[NumButtons-1:0]),
    .cfg       (cfg_r),
    .hold      (ob_full),
    .res_vld   (res_vld),
    .res       (res)
  );

  // result register plus skid toward the receiver
  bccd_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_vld),
    .push_res   (res),
    .full       (ob_full),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  // pack result fields, click kind in the low bits
  assign out_tdata = {1'b0, out_res.stable_buttons, out_res.long_press,
                      out_res.click_kind};

endmodule

// ===== verif/tb.sv =====
// self-checking bench for button_click_combo_detector
// depends on bccd_pkg and the design top level; a built-in click predictor
// tracks every input beat and the result beats are compared in order
`timescale 1ns / 1ps

module tb;
  import bccd_pkg::*;

  // no accepted beat or register write for this many cycles ends the run
  localparam int QuietLimit = 5000;
  // cycles the receiver refuses results during the back-pressure stretch
  localparam int StallCycles = 300;
  // cycles let pass after the last result before a register write or the end
  localparam int SettleCycles = 4;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_we     = 1'b0;
  logic                cfg_addr   = CfgDebounce;
  logic [CntW-1:0]     cfg_wdata  = '0;

  // idle percentages of the sender and the receiver, changed per phase
  int send_idle_pct = 22;
  int recv_idle_pct = 69;

  int errors      = 0;
  int items_sent  = 0;
  int quiet_cycles = 0;

  // back-pressure request: the initial block bumps stall_asks, the receiver
  // notices the difference and starts its own countdown
  int stall_asks = 0;
  int stall_seen = 0;
  int stall_left = 0;

  // click predictor state
  logic [CntW-1:0]   pred_debounce;
  logic [CntW-1:0]   pred_long;
  logic [StampW-1:0] tick_cnt;
  btn_t              prev_raw;
  btn_t              captured;
  btn_t              stable;
  btn_t              last_valid;
  btn_t              busy;
  btn_t              finished;
  logic [CntW-1:0]   countdown  [NumButtons];
  logic [StampW-1:0] press_t    [NumButtons];
  logic [StampW-1:0] release_t  [NumButtons];

  // clicks predicted but not yet seen on the result side
  result_t pending_clicks[$];

  button_click_combo_detector u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  task automatic clear_predictor();
    pred_debounce = DebounceReset;
    pred_long     = LongReset;
    tick_cnt      = '0;
    prev_raw      = '1;
    captured      = '1;
    stable        = '1;
    last_valid    = '1;
    busy          = '0;
    finished      = '0;
    for (int i = 0; i < NumButtons; i++) begin
      countdown[i] = '0;
      press_t[i]   = '0;
      release_t[i] = '0;
    end
  endtask

  // held time is release stamp minus press stamp, wrapping at 32 bits
  function automatic logic held_at_least(input int b);
    logic [StampW-1:0] held;
    held = release_t[b] - press_t[b];
    return held >= StampW'(pred_long);
  endfunction

  // a click is one or more buttons going from pressed (last valid) to released (now)
  // with the other buttons unchanged; only some kinds can be long
  function automatic kind_t click_of(input btn_t now, input btn_t was, output logic lng);
    lng = 1'b0;
    if (now == 3'b111 && was == 3'b000)
      return KIND_ALL;
    if (now[0] && now[1] && !was[0] && !was[1] && now[2] == was[2]) begin
      lng = held_at_least(0) && held_at_least(1);
      return KIND_B1B2;
    end
    if (now[0] && now[2] && !was[0] && !was[2] && now[1] == was[1])
      return KIND_B1B3;
    if (now[1] && now[2] && !was[1] && !was[2] && now[0] == was[0]) begin
      lng = held_at_least(1) && held_at_least(2);
      return KIND_B2B3;
    end
    if (now[0] && !was[0] && now[2:1] == was[2:1]) begin
      lng = held_at_least(0);
      return KIND_B1;
    end
    if (now[1] && !was[1] && now[0] == was[0] && now[2] == was[2])
      return KIND_B2;
    if (now[2] && !was[2] && now[1:0] == was[1:0]) begin
      lng = held_at_least(2);
      return KIND_B3;
    end
    return KIND_NONE;
  endfunction

  // advance the predictor by one tick
  task automatic predict_tick(input btn_t raw);
    btn_t            restarted;
    logic            expired;
    logic [CntW-1:0] len;
    result_t         click;
    logic            lng;
    len       = (pred_debounce == '0) ? CntW'(1) : pred_debounce;
    restarted = '0;
    expired   = 1'b0;
    // edges first: capture, and restart the countdown if it departs from
    // the last valid level
    for (int i = 0; i < NumButtons; i++) begin
      if (raw[i] != prev_raw[i]) begin
        captured[i] = raw[i];
        if (raw[i] != last_valid[i]) begin
          busy[i]      = 1'b1;
          finished[i]  = 1'b0;
          countdown[i] = len;
          restarted[i] = 1'b1;
        end
      end
    end
    prev_raw = raw;
    // countdowns loaded this tick hold, the rest decrement
    for (int i = 0; i < NumButtons; i++) begin
      if (!restarted[i] && countdown[i] != '0) begin
        countdown[i] = countdown[i] - CntW'(1);
        if (countdown[i] == '0) begin
          finished[i] = 1'b1;
          expired     = 1'b1;
        end
      end
    end
    // snapshot once no busy button is still counting
    if (expired && (busy & ~finished) == '0) begin
      for (int i = 0; i < NumButtons; i++) begin
        if (raw[i] == captured[i]) begin
          stable[i] = captured[i];
          if (stable[i])
            release_t[i] = tick_cnt;
          else
            press_t[i] = tick_cnt;
        end
      end
      busy     = '0;
      finished = '0;
      click.click_kind     = click_of(stable, last_valid, lng);
      click.long_press     = lng;
      click.stable_buttons = stable;
      last_valid = stable;
      pending_clicks.push_back(click);
    end
    tick_cnt = tick_cnt + StampW'(1);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // offer one tick; in_tvalid stays high on return so a following call can
  // reuse the slot, and wait_idle lowers it when the stream pauses
  task automatic send_tick(input btn_t raw);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct)
        @(posedge clk);
    end
    in_tdata  <= {{(InDataW-NumButtons){1'b0}}, raw};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    predict_tick(raw);
    items_sent++;
  endtask

  task automatic hold_level(input btn_t raw, input int n);
    repeat (n) send_tick(raw);
  endtask

  // stop offering, let every predicted click drain, then let the pipeline settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_clicks.size() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // both registers, back to back, only while idle
  task automatic set_config(input logic [CntW-1:0] deb, input logic [CntW-1:0] lng);
    cfg_we    <= 1'b1;
    cfg_addr  <= CfgDebounce;
    cfg_wdata <= deb;
    @(posedge clk);
    cfg_addr  <= CfgLong;
    cfg_wdata <= lng;
    @(posedge clk);
    cfg_we    <= 1'b0;
    pred_debounce = deb;
    pred_long     = lng;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset lengths: 50 tick debounce, short hold is never long
  task automatic test_reset_values();
    hold_level(3'b110, 55);
    hold_level(3'b111, 55);
    wait_idle();
  endtask

  // every click kind once, zero debounce acting as one, zero long length
  task automatic test_every_kind();
    btn_t masks [7];
    masks = '{3'b111, 3'b011, 3'b101, 3'b110, 3'b001, 3'b010, 3'b100};
    set_config(16'd0, 16'd0);
    foreach (masks[k]) begin
      hold_level(~masks[k], 2);
      hold_level(3'b111, 2);
    end
    wait_idle();
  endtask

  // contact bounce back to the valid level, staggered presses whose
  // countdowns overlap, simultaneous expiry
  task automatic test_bounce_and_overlap();
    set_config(16'd3, 16'd1);
    // short glitch: snapshot with nothing changed
    hold_level(3'b110, 1);
    hold_level(3'b111, 5);
    // b1 then b2 a tick later: one snapshot only when both are done
    hold_level(3'b110, 1);
    hold_level(3'b100, 5);
    hold_level(3'b111, 5);
    // b2 and b3 together, released one tick apart
    hold_level(3'b001, 5);
    hold_level(3'b011, 1);
    hold_level(3'b111, 5);
    wait_idle();
  endtask

  // long length of 40 ticks: held exactly that long, then one tick less
  task automatic test_long_limits();
    set_config(16'd1, 16'd40);
    hold_level(3'b011, 40);
    hold_level(3'b111, 3);
    hold_level(3'b110, 39);
    hold_level(3'b111, 3);
    hold_level(3'b101, 5);
    hold_level(3'b111, 3);
    wait_idle();
  endtask

  // long debounce length on a b1+b3 press, released with a short one
  task automatic test_debounce_limit();
    set_config(16'd60, LongReset);
    hold_level(3'b010, 62);
    wait_idle();
    set_config(16'd1, LongReset);
    hold_level(3'b111, 3);
    wait_idle();
  endtask

  // mostly press and release gestures with random masks, holds, bounce and
  // staggering, the rest random noise; optionally one long result stall
  task automatic random_gestures(input int n_items, input bit with_stall);
    int   first;
    int   len;
    bit   stalled;
    btn_t mask;
    btn_t low_bit;
    first   = items_sent;
    stalled = 1'b0;
    len     = (pred_debounce == '0) ? 1 : int'(pred_debounce);
    while (items_sent - first < n_items) begin
      if (with_stall && !stalled && items_sent - first > n_items / 3) begin
        stall_asks++;
        stalled = 1'b1;
      end
      if ($urandom_range(9) < 8) begin
        mask    = btn_t'($urandom_range(1, 7));
        low_bit = mask & (~mask + btn_t'(1));
        if ($urandom_range(3) == 0)
          repeat ($urandom_range(1, 3)) hold_level(btn_t'($urandom), 1);
        if ($urandom_range(3) == 0 && mask != low_bit)
          hold_level(~low_bit, $urandom_range(1, len));
        hold_level(~mask, $urandom_range(1, len + 10));
        if ($urandom_range(3) == 0 && mask != low_bit)
          hold_level(~(mask & ~low_bit), $urandom_range(1, len));
        hold_level(3'b111, $urandom_range(len + 1, len + 6));
      end else begin
        repeat ($urandom_range(1, 6)) hold_level(btn_t'($urandom), $urandom_range(1, 3));
      end
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // receiver: random ready, or a counted hold-off when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_asks != stall_seen) begin
      stall_seen <= stall_asks;
      stall_left <= StallCycles;
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare every result beat with the oldest predicted click
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata[$bits(result_t)-1:0]);
      if (pending_clicks.size() == 0) begin
        $display("%0t unexpected result beat, expected none, got %h", $time, out_tdata);
        errors++;
      end else begin
        want = pending_clicks.pop_front();
        if (got.click_kind != want.click_kind) begin
          $display("%0t click_kind expected %0d got %0d", $time, want.click_kind,
                   got.click_kind);
          errors++;
        end
        if (got.long_press != want.long_press) begin
          $display("%0t long_press expected %0d got %0d", $time, want.long_press,
                   got.long_press);
          errors++;
        end
        if (got.stable_buttons != want.stable_buttons) begin
          $display("%0t stable_buttons expected %b got %b", $time, want.stable_buttons,
                   got.stable_buttons);
          errors++;
        end
      end
    end
  end

  // watchdog: too long without any beat or register write
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("FAIL button_click_combo_detector");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    clear_predictor();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // phase one: sender idles a little, receiver a lot
    send_idle_pct = 22;
    recv_idle_pct = 69;
    test_reset_values();
    test_every_kind();
    test_bounce_and_overlap();
    set_config(CntW'($urandom_range(1, 3)), CntW'($urandom_range(0, 8)));
    random_gestures(470, 1'b1);

    // phase two: the other way round
    send_idle_pct = 69;
    recv_idle_pct = 22;
    set_config(CntW'($urandom_range(2, 6)), CntW'($urandom_range(5, 25)));
    random_gestures(470, 1'b0);

    // phase three: no idling, exact long length and a long debounce
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_long_limits();
    test_debounce_limit();
    set_config(16'd1, CntW'($urandom_range(0, 15)));
    random_gestures(470, 1'b1);

    if (errors == 0)
      $display("PASS button_click_combo_detector");
    else
      $display("FAIL button_click_combo_detector");
    $finish;
  end

endmodule
